### sv/sdt_pkg.sv
// ============================================================================
// sdt_pkg - shared types and constants of the SDT section parser
// Parse phases, result word layout, status codes and result queue sizing.
// ============================================================================
package sdt_pkg;

    localparam int MIN_SECTION_BYTES  = 15;
    localparam int ENTRY_HEADER_BYTES = 5;
    localparam int MAX_PAYLOAD_BYTES  = 184;
    localparam int SECTION_OVERHEAD   = 12;

    // Register indexes of the configuration port.
    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_TABLE_ID    = 1'b1;

    localparam logic [7:0] MAX_ENTRIES_RESET = 8'd16;
    localparam logic [7:0] TABLE_ID_RESET    = 8'h42;

    // Result kinds and summary status codes.
    localparam logic       KIND_ENTRY   = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_FORMAT    = 2'd2;

    // Result queue: one byte can produce two words, so two slots must be free.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SKIP_PTR,
        PH_TABLE_ID,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_FIXED,
        PH_ENTRY_HDR,
        PH_DESC_SKIP,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] svc_id;
        logic        eit_schedule;
        logic        eit_present;
        logic [2:0]  run_status;
        logic [11:0] desc_len;
        logic [15:0] stream_id_out;
        logic [15:0] network_id_out;
        logic [7:0]  table_id_out;
        logic [1:0]  status;
        logic [7:0]  entry_count;
        logic        last_result;
    } result_t;

    // Words produced by one byte: count 0, 1 or 2, first word in res_a.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res_a;
        result_t    res_b;
    } push_t;

endpackage

### sv/sdt_core.sv
// ============================================================================
// sdt_core - per-byte section parse
// Holds the parse state and configuration and turns each accepted byte into
// zero, one or two result words.
// ============================================================================
module sdt_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    input  logic           payload_start,
    input  logic [7:0]     payload_length,
    input  logic           first_byte,
    input  logic           last_byte,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_data,
    output sdt_pkg::push_t push
);
    import sdt_pkg::*;

    logic [7:0]         max_entries_reg;
    logic [7:0]         table_id_cfg_reg;

    phase_t             phase_reg, phase_next;
    logic [7:0]         pointer_skip_reg, pointer_skip_next;
    logic signed [9:0]  left_count_reg, left_count_next;
    logic [11:0]        section_length_reg, section_length_next;
    logic signed [12:0] section_remaining_reg, section_remaining_next;
    logic [11:0]        descriptor_skip_reg, descriptor_skip_next;
    logic [31:0]        entry_shift_reg, entry_shift_next;
    logic [2:0]         header_byte_count_reg, header_byte_count_next;
    logic [7:0]         services_seen_reg, services_seen_next;
    logic [15:0]        ts_id_reg, ts_id_next;
    logic [15:0]        network_id_reg, network_id_next;
    logic [7:0]         table_id_reg, table_id_next;
    logic               error_flag_reg, error_flag_next;
    logic               overflow_flag_reg, overflow_flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg  <= MAX_ENTRIES_RESET;
            table_id_cfg_reg <= TABLE_ID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ENTRIES: max_entries_reg  <= cfg_data;
                CFG_TABLE_ID:    table_id_cfg_reg <= cfg_data;
                default:         max_entries_reg  <= max_entries_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_IDLE;
            pointer_skip_reg      <= '0;
            left_count_reg        <= '0;
            section_length_reg    <= '0;
            section_remaining_reg <= '0;
            descriptor_skip_reg   <= '0;
            entry_shift_reg       <= '0;
            header_byte_count_reg <= '0;
            services_seen_reg     <= '0;
            ts_id_reg             <= '0;
            network_id_reg        <= '0;
            table_id_reg          <= '0;
            error_flag_reg        <= 1'b0;
            overflow_flag_reg     <= 1'b0;
        end
        else
        begin
            phase_reg             <= phase_next;
            pointer_skip_reg      <= pointer_skip_next;
            left_count_reg        <= left_count_next;
            section_length_reg    <= section_length_next;
            section_remaining_reg <= section_remaining_next;
            descriptor_skip_reg   <= descriptor_skip_next;
            entry_shift_reg       <= entry_shift_next;
            header_byte_count_reg <= header_byte_count_next;
            services_seen_reg     <= services_seen_next;
            ts_id_reg             <= ts_id_next;
            network_id_reg        <= network_id_next;
            table_id_reg          <= table_id_next;
            error_flag_reg        <= error_flag_next;
            overflow_flag_reg     <= overflow_flag_next;
        end
    end

    always_comb
    begin
        logic        consumed;
        logic [7:0]  plen_sat;
        logic [39:0] hdr;
        logic [11:0] dl;
        logic [11:0] sl;
        result_t     entry;
        result_t     summary;
        logic        emit;

        phase_next             = phase_reg;
        pointer_skip_next      = pointer_skip_reg;
        left_count_next        = left_count_reg;
        section_length_next    = section_length_reg;
        section_remaining_next = section_remaining_reg;
        descriptor_skip_next   = descriptor_skip_reg;
        entry_shift_next       = entry_shift_reg;
        header_byte_count_next = header_byte_count_reg;
        services_seen_next     = services_seen_reg;
        ts_id_next             = ts_id_reg;
        network_id_next        = network_id_reg;
        table_id_next          = table_id_reg;
        error_flag_next        = error_flag_reg;
        overflow_flag_next     = overflow_flag_reg;
        consumed               = 1'b0;
        plen_sat               = payload_length;
        hdr                    = '0;
        dl                     = '0;
        sl                     = '0;
        entry                  = '0;
        summary                = '0;
        emit                   = 1'b0;
        push                   = '0;

        if (accept && (first_byte || phase_reg != PH_IDLE))
        begin
            if (first_byte)
            begin
                // A first byte always restarts the packet from clean state.
                if (payload_length > 8'(MAX_PAYLOAD_BYTES))
                begin
                    plen_sat = 8'(MAX_PAYLOAD_BYTES);
                end
                error_flag_next        = 1'b0;
                overflow_flag_next     = 1'b0;
                services_seen_next     = '0;
                ts_id_next             = '0;
                network_id_next        = '0;
                table_id_next          = '0;
                section_length_next    = '0;
                section_remaining_next = '0;
                descriptor_skip_next   = '0;
                header_byte_count_next = '0;
                entry_shift_next       = '0;
                if (payload_start)
                begin
                    pointer_skip_next = data_byte;
                    left_count_next   = $signed({2'b00, plen_sat}) - 10'sd1
                                        - $signed({2'b00, data_byte});
                    phase_next        = (data_byte != 8'd0) ? PH_SKIP_PTR : PH_TABLE_ID;
                    consumed          = 1'b1;
                end
                else
                begin
                    pointer_skip_next = '0;
                    left_count_next   = $signed({2'b00, plen_sat});
                    phase_next        = PH_TABLE_ID;
                end
            end

            if (!consumed)
            begin
                case (phase_next)
                    PH_SKIP_PTR:
                    begin
                        pointer_skip_next = pointer_skip_next - 8'd1;
                        if (pointer_skip_next == 8'd0)
                        begin
                            phase_next = PH_TABLE_ID;
                        end
                    end
                    PH_TABLE_ID:
                    begin
                        table_id_next = data_byte;
                        if (data_byte != table_id_cfg_reg ||
                            left_count_next < 10'(MIN_SECTION_BYTES))
                        begin
                            error_flag_next = 1'b1;
                            phase_next      = PH_DONE;
                        end
                        else
                        begin
                            left_count_next = left_count_next - 10'sd3;
                            phase_next      = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        section_length_next = {data_byte[3:0], 8'd0};
                        phase_next          = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        sl                  = {section_length_next[11:8], data_byte};
                        section_length_next = sl;
                        if ($signed({2'b00, sl}) > 14'(left_count_next))
                        begin
                            error_flag_next = 1'b1;
                            phase_next      = PH_DONE;
                        end
                        else
                        begin
                            section_remaining_next = $signed({1'b0, sl})
                                                     - 13'(SECTION_OVERHEAD);
                            header_byte_count_next = '0;
                            phase_next             = PH_FIXED;
                        end
                    end
                    PH_FIXED:
                    begin
                        case (header_byte_count_next)
                            3'd0:    ts_id_next      = {data_byte, 8'd0};
                            3'd1:    ts_id_next      = {ts_id_next[15:8], data_byte};
                            3'd5:    network_id_next = {data_byte, 8'd0};
                            3'd6:    network_id_next = {network_id_next[15:8], data_byte};
                            default: ts_id_next      = ts_id_next;
                        endcase
                        if (header_byte_count_next == 3'd7)
                        begin
                            if (section_remaining_next >= 13'(ENTRY_HEADER_BYTES))
                            begin
                                phase_next = PH_ENTRY_HDR;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                            header_byte_count_next = '0;
                            entry_shift_next       = '0;
                        end
                        else
                        begin
                            header_byte_count_next = header_byte_count_next + 3'd1;
                        end
                    end
                    PH_ENTRY_HDR:
                    begin
                        hdr              = {entry_shift_next, data_byte};
                        entry_shift_next = {entry_shift_next[23:0], data_byte};
                        if (header_byte_count_next == 3'(ENTRY_HEADER_BYTES - 1))
                        begin
                            dl   = {hdr[11:8], hdr[7:0]};
                            emit = services_seen_next < max_entries_reg;
                            section_remaining_next = section_remaining_next
                                                     - 13'(ENTRY_HEADER_BYTES)
                                                     - $signed({1'b0, dl});
                            if (services_seen_next != 8'hFF)
                            begin
                                services_seen_next = services_seen_next + 8'd1;
                            end
                            if (!emit)
                            begin
                                overflow_flag_next = 1'b1;
                            end
                            entry.result_kind      = KIND_ENTRY;
                            entry.svc_id           = hdr[39:24];
                            entry.eit_schedule     = hdr[17];
                            entry.eit_present      = hdr[16];
                            entry.run_status       = hdr[15:13];
                            entry.desc_len         = dl;
                            entry.stream_id_out    = ts_id_next;
                            entry.network_id_out   = network_id_next;
                            entry.table_id_out     = table_id_next;
                            entry.status           = ST_OK;
                            entry.entry_count      = services_seen_next;
                            entry.last_result      = 1'b0;
                            header_byte_count_next = '0;
                            entry_shift_next       = '0;
                            if (dl != 12'd0)
                            begin
                                descriptor_skip_next = dl;
                                phase_next           = PH_DESC_SKIP;
                            end
                            else if (section_remaining_next >= 13'(ENTRY_HEADER_BYTES))
                            begin
                                phase_next = PH_ENTRY_HDR;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        else
                        begin
                            header_byte_count_next = header_byte_count_next + 3'd1;
                        end
                    end
                    PH_DESC_SKIP:
                    begin
                        descriptor_skip_next = descriptor_skip_next - 12'd1;
                        if (descriptor_skip_next == 12'd0)
                        begin
                            header_byte_count_next = '0;
                            entry_shift_next       = '0;
                            if (section_remaining_next >= 13'(ENTRY_HEADER_BYTES))
                            begin
                                phase_next = PH_ENTRY_HDR;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_next;
                    end
                endcase
            end

            summary.result_kind    = KIND_SUMMARY;
            summary.stream_id_out  = ts_id_next;
            summary.network_id_out = network_id_next;
            summary.table_id_out   = table_id_next;
            summary.entry_count    = services_seen_next;
            summary.last_result    = 1'b1;
            if (error_flag_next)
            begin
                summary.status = ST_FORMAT;
            end
            else if (phase_next != PH_DESC_SKIP && phase_next != PH_DONE)
            begin
                summary.status = ST_FORMAT;
            end
            else
            begin
                summary.status = overflow_flag_next ? ST_OVERFLOW : ST_OK;
            end

            if (emit)
            begin
                push.res_a = entry;
                push.res_b = summary;
                push.cnt   = last_byte ? 2'd2 : 2'd1;
            end
            else if (last_byte)
            begin
                push.res_a = summary;
                push.cnt   = 2'd1;
            end

            if (last_byte)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

endmodule

### sv/sdt_rfifo.sv
// ============================================================================
// sdt_rfifo - result word queue
// Small register queue that takes up to two words a cycle and hands one out.
// ============================================================================
module sdt_rfifo (
    input  logic             clk,
    input  logic             rst_n,
    input  sdt_pkg::push_t   push,
    input  logic             pop,
    output sdt_pkg::result_t head,
    output logic             not_empty,
    output logic             full_for_two
);
    import sdt_pkg::*;

    result_t             slot_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [RQ_CW-1:0]    count_reg, count_next;
    logic                do_pop;

    assign not_empty    = count_reg != '0;
    assign full_for_two = count_reg > RQ_CW'(RQ_DEPTH - 2);
    assign head         = slot_reg[rd_ptr_reg];
    assign do_pop       = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_AW'(push.cnt);
        rd_ptr_next = do_pop ? rd_ptr_reg + RQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + RQ_CW'(push.cnt) - RQ_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.res_a;
        end
        if (push.cnt == 2'd2)
        begin
            slot_reg[wr_ptr_reg + RQ_AW'(1)] <= push.res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/dvb_sdt_section_parser.sv
// ============================================================================
// dvb_sdt_section_parser - SDT actual section parser, one payload byte a cycle
// Results: each word is written into the result queue when its byte is accepted;
// when one byte gives an entry and the summary, the entry is presented first.
// Throughput: one byte a cycle; input stalls only while three or more words wait.
// Reset: parse idle, queue empty, max_entries 16, actual_table_id 0x42.
// ============================================================================
module dvb_sdt_section_parser (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    // Input channel: one payload byte per word.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        payload_start,
    input  logic [7:0]  payload_length,
    input  logic        first_byte,
    input  logic        last_byte,

    // Output channel: one entry or summary result per word.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [15:0] svc_id,
    output logic        eit_schedule,
    output logic        eit_present,
    output logic [2:0]  run_status,
    output logic [11:0] desc_len,
    output logic [15:0] stream_id_out,
    output logic [15:0] network_id_out,
    output logic [7:0]  table_id_out,
    output logic [1:0]  status,
    output logic [7:0]  entry_count,
    output logic        last_result
);
    import sdt_pkg::*;

    push_t   push;
    result_t head;
    logic    accept;
    logic    q_not_empty;
    logic    q_tight;

    // The input side is held off only when the result queue cannot take the
    // two words the next byte may produce. The stall comes from the queue
    // fill level register, so it never looks at the incoming valid. Entry
    // words are at least five bytes apart, so a consumer that takes every
    // word never causes a stall.
    assign in_stall = q_tight;
    assign accept   = in_valid && !in_stall;

    // The parse core handles the whole byte in the cycle it is accepted:
    // phase sequencing, pointer and descriptor skip counters, the length
    // checks and the entry header capture all update in one step, and the
    // resulting words are written straight into the queue.
    sdt_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .payload_start  (payload_start),
        .payload_length (payload_length),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push)
    );

    // The queue separates the two sides, so a stalled consumer does not
    // stop bytes from flowing in until the queue is nearly full. When an
    // entry and the summary come from the same byte, the entry leaves first.
    sdt_rfifo u_rfifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .pop          (!out_stall),
        .head         (head),
        .not_empty    (q_not_empty),
        .full_for_two (q_tight)
    );

    assign out_valid      = q_not_empty;
    assign result_kind    = head.result_kind;
    assign svc_id         = head.svc_id;
    assign eit_schedule   = head.eit_schedule;
    assign eit_present    = head.eit_present;
    assign run_status     = head.run_status;
    assign desc_len       = head.desc_len;
    assign stream_id_out  = head.stream_id_out;
    assign network_id_out = head.network_id_out;
    assign table_id_out   = head.table_id_out;
    assign status         = head.status;
    assign entry_count    = head.entry_count;
    assign last_result    = head.last_result;

endmodule
